// ----- design/b64qd_pkg.sv -----
// Types, code constants and the character-to-code map for the Base64 quad decoder.
// No dependencies; imported by b64qd_quad_decode and base64_quad_decoder.
package b64qd_pkg;

    localparam int unsigned CodeWidth = 7;
    localparam int unsigned HeldDepth = 3;

    typedef logic [CodeWidth-1:0] code_t;

    localparam code_t CODE_PAD = 7'd64;
    localparam code_t CODE_BAD = 7'd65;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_EQUAL = 8'h3D;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_string;
    } in_word_t;

    typedef struct packed {
        logic [7:0] decoded_byte0;
        logic [7:0] decoded_byte1;
        logic [7:0] decoded_byte2;
        logic       quad_valid;
    } out_word_t;

    function automatic code_t char_code(input logic [7:0] ch);
        logic [7:0] diff;
        diff = 8'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            diff = ch - 8'h41;
            return diff[CodeWidth-1:0];
        end
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            diff = ch - 8'h61 + 8'd26;
            return diff[CodeWidth-1:0];
        end
        if (ch >= 8'h30 && ch <= 8'h39) begin
            diff = ch - 8'h30 + 8'd52;
            return diff[CodeWidth-1:0];
        end
        if (ch == CHAR_PLUS) begin
            return 7'd62;
        end
        if (ch == CHAR_SLASH) begin
            return 7'd63;
        end
        if (ch == CHAR_EQUAL) begin
            return CODE_PAD;
        end
        return CODE_BAD;
    endfunction

endpackage

// ----- design/b64qd_quad_decode.sv -----
// Combinational decode of four character codes into three bytes and a valid flag.
// Depends on b64qd_pkg for the code type, padding/invalid codes and result word type.
module b64qd_quad_decode (
    input  b64qd_pkg::code_t     code0,
    input  b64qd_pkg::code_t     code1,
    input  b64qd_pkg::code_t     code2,
    input  b64qd_pkg::code_t     code3,
    output b64qd_pkg::out_word_t word
);
    import b64qd_pkg::*;

    logic       ok;
    logic       c2_data;
    logic       c3_data;
    logic [1:0] low2;

    assign ok      = !code0[6] && !code1[6] && (code2 != CODE_BAD) && (code3 != CODE_BAD);
    assign c2_data = !code2[6];
    assign c3_data = !code3[6];
    assign low2    = c2_data ? code2[1:0] : 2'b11;

    always_comb begin
        word = '0;
        if (ok) begin
            word.quad_valid    = 1'b1;
            word.decoded_byte0 = {code0[5:0], code1[5:4]};
            if (c2_data) begin
                word.decoded_byte1 = {code1[3:0], code2[5:2]};
            end
            if (c3_data) begin
                word.decoded_byte2 = {low2, code3[5:0]};
            end
        end
    end

endmodule

// ----- design/base64_quad_decoder.sv -----
// Top level of the Base64 quad decoder: input register, held codes, result register.
// Depends on b64qd_pkg and b64qd_quad_decode.
//
// Takes one Base64 character per cycle on the s_ channel and gives one result word on the
// m_ channel for every fourth character: three decoded bytes and a flag that is low when
// the quad is rejected. A word with end_of_string set restarts the quad position; a partial
// quad is dropped with no result. Throughput is one character per cycle as long as m_ready
// keeps up. A character passes through the input register before it reaches the result register, so
// m_valid rises once the fourth character moves on from the input register. The rate is set
// by the single input register feeding the result register; s_ready follows m_ready only
// while a fourth character waits behind a full result register.
module base64_quad_decoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  b64qd_pkg::in_word_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b64qd_pkg::out_word_t  m_data
);
    import b64qd_pkg::*;

    in_word_t   in_reg;
    logic       in_valid_reg;
    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    code_t      held_reg [HeldDepth];
    code_t      cur_code;
    out_word_t  out_reg;
    out_word_t  quad_word;
    logic       m_valid_reg;
    logic       out_free;
    logic       fourth;
    logic       in_move;
    logic       out_load;

    assign cur_code = char_code(in_reg.text_char);
    assign fourth   = (pos_reg == 2'd3);
    assign out_free = !m_valid_reg || m_ready;
    assign in_move  = in_valid_reg && (!fourth || out_free);
    assign out_load = in_move && fourth;
    assign s_ready  = !in_valid_reg || in_move;

    always_comb begin
        pos_next = pos_reg;
        if (in_move) begin
            if (fourth || in_reg.end_of_string) begin
                pos_next = 2'd0;
            end else begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    b64qd_quad_decode u_decode (
        .code0 (held_reg[0]),
        .code1 (held_reg[1]),
        .code2 (held_reg[2]),
        .code3 (cur_code),
        .word  (quad_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            pos_reg      <= 2'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            pos_reg <= pos_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (in_move && !fourth) begin
            held_reg[pos_reg] <= cur_code;
        end
        if (out_load) begin
            out_reg <= quad_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_load_on_fourth : assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (pos_reg == 2'd3))
        else $error("result loaded away from the fourth character");

    a_pos_restart : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_move && (fourth || in_reg.end_of_string)) |=> (pos_reg == 2'd0))
        else $error("quad position did not restart");

    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !out_load)
        else $error("pending result overwritten");

    a_hold_stalled : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_move) |=> (in_valid_reg && $stable(pos_reg)))
        else $error("stalled character lost");

endmodule
